@@ src/four_level_page_table_walker_core_assert.svh @@
// assertion macros for the page table walker checker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

// property checked outside reset
`define PTW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define PTW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ptw_pkg.sv @@
package ptw_pkg;

	localparam int IN_TDATA_W  = 184;
	localparam int OUT_TDATA_W = 120;

	localparam logic [63:0] KIMAGE_PHYS_START = 64'h0000_0000_0100_0000;
	localparam logic [63:0] DIRECT_MAP_BASE   = 64'hffff_8880_0000_0000;
	localparam logic [63:0] KIMAGE_BASE       = 64'hffff_ffff_8000_0000;
	// offsets added to a root pointer, wrapping modulo 2^64
	localparam logic [63:0] KIMAGE_OFFSET     = KIMAGE_PHYS_START - KIMAGE_BASE;
	localparam logic [63:0] DIRECT_OFFSET     = 64'd0 - DIRECT_MAP_BASE;

	localparam logic REQ_TRANSLATE = 1'b0;
	localparam logic REQ_RESPONSE  = 1'b1;
	localparam logic RSP_READ      = 1'b0;
	localparam logic RSP_DONE      = 1'b1;

	localparam logic [1:0] LEVEL_LAST = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [63:0] root_pointer;
		logic [47:0] virtual_address;
		logic [63:0] entry_data;
		logic        read_ok;
	} item_t;

	typedef struct packed {
		logic        rsp_kind;
		logic [63:0] read_address;
		logic [51:0] physical_address;
		logic        fault;
	} result_t;

endpackage

@@ src/ptw_in_reg.sv @@
module ptw_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ptw_pkg::item_t in_item,
	input  logic          advance,
	output logic          valid_s1,
	output ptw_pkg::item_t item_s1
);

	// take a new item whenever the register is empty or the held one moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ src/ptw_step.sv @@
module ptw_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  ptw_pkg::item_t  item_s1,
	output logic            res_valid,
	output ptw_pkg::result_t res
);

	logic        walking_q;
	logic [1:0]  level_q;
	logic [47:0] saved_vaddr_q;

	logic [8:0]  next_index;
	logic [63:0] root_offset;
	logic        start_walk;
	logic        step_walk;
	logic        end_walk;

	always_comb begin
		unique case (level_q)
			2'd0:    next_index = saved_vaddr_q[38:30];
			2'd1:    next_index = saved_vaddr_q[29:21];
			2'd2:    next_index = saved_vaddr_q[20:12];
			default: next_index = 9'd0;
		endcase
	end

	assign root_offset = (item_s1.root_pointer >= ptw_pkg::KIMAGE_BASE) ?
		ptw_pkg::KIMAGE_OFFSET : ptw_pkg::DIRECT_OFFSET;

	assign start_walk = (item_s1.req_type == ptw_pkg::REQ_TRANSLATE) && !walking_q;
	assign step_walk  = (item_s1.req_type == ptw_pkg::REQ_RESPONSE) && walking_q;
	assign end_walk   = step_walk && (!item_s1.read_ok || level_q == ptw_pkg::LEVEL_LAST);

	always_comb begin
		res       = '0;
		res_valid = start_walk || step_walk;
		priority if (start_walk) begin
			res.rsp_kind     = ptw_pkg::RSP_READ;
			res.read_address = item_s1.root_pointer + root_offset +
				{52'd0, item_s1.virtual_address[47:39], 3'b000};
		end else if (step_walk && !item_s1.read_ok) begin
			res.rsp_kind = ptw_pkg::RSP_DONE;
			res.fault    = 1'b1;
		end else if (step_walk && level_q == ptw_pkg::LEVEL_LAST) begin
			res.rsp_kind         = ptw_pkg::RSP_DONE;
			res.physical_address = {item_s1.entry_data[51:12], saved_vaddr_q[11:0]};
		end else if (step_walk) begin
			// frame bits sit above the index, so no carry can arise
			res.rsp_kind     = ptw_pkg::RSP_READ;
			res.read_address = {12'd0, item_s1.entry_data[51:12], next_index, 3'b000};
		end else begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
			level_q   <= 2'd0;
		end else if (advance) begin
			if (start_walk) begin
				walking_q <= 1'b1;
				level_q   <= 2'd0;
			end else if (end_walk) begin
				walking_q <= 1'b0;
				level_q   <= 2'd0;
			end else if (step_walk) begin
				level_q <= level_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && start_walk) begin
			saved_vaddr_q <= item_s1.virtual_address;
		end
	end

endmodule

@@ src/ptw_out_reg.sv @@
module ptw_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  logic             res_valid,
	input  ptw_pkg::result_t res,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_ready,
	output ptw_pkg::result_t out_res
);

	// the held item moves on once the result register is empty or being read out
	assign advance = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res <= res;
		end
	end

endmodule

@@ src/four_level_page_table_walker_core.sv @@
// four level page table walker
// s_axis carries both translate requests and memory read responses:
//   tuser selects the kind (0 translate request, 1 read response)
//   tdata holds root pointer, virtual address, table entry and read status
// m_axis carries read requests to memory and finished translations:
//   tuser 0 asks for an 8-byte entry at read_address
//   tuser 1 ends a walk with physical_address, or fault set and address 0
// a walk is one translate request and four read responses, each answered by
// exactly one m_axis transfer; a failed read ends the walk early
// a request during a walk or a response outside one gives no transfer
// an s_axis transfer is registered in the input register, then its result in the result register
// with m_axis ready, one s_axis transfer per cycle is sustained; the walk rate is
// set only by the memory round trip between read request and read response
// a stall on m_axis holds the result register; one further item may wait in
// the input register, after which s_axis tready falls
// reset clears both valid flags and returns the walker to idle
module four_level_page_table_walker_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// root_pointer[63:0], virtual_address[111:64], entry_data[175:112],
	// read_ok[176], zero fill[183:177]
	input  logic [ptw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// read_address[63:0], physical_address[115:64], fault[116], zero fill[119:117]
	output logic [ptw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// rsp_kind
	output logic                              m_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready
);

	ptw_pkg::item_t   in_item;
	ptw_pkg::item_t   item_s1;
	ptw_pkg::result_t res;
	ptw_pkg::result_t out_res;
	logic             valid_s1;
	logic             advance;
	logic             res_valid;

	// unpack the input transfer
	assign in_item.req_type        = s_axis_tuser;
	assign in_item.root_pointer    = s_axis_tdata[63:0];
	assign in_item.virtual_address = s_axis_tdata[111:64];
	assign in_item.entry_data      = s_axis_tdata[175:112];
	assign in_item.read_ok         = s_axis_tdata[176];

	// input register
	ptw_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// walk state and single step of address logic
	ptw_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register, decoupled from the input side
	ptw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// pack the output transfer
	assign m_axis_tuser = out_res.rsp_kind;
	assign m_axis_tdata = {3'b000, out_res.fault, out_res.physical_address,
		out_res.read_address};

endmodule

@@ src/ptw_checker.sv @@
`include "four_level_page_table_walker_core_assert.svh"

module ptw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic [ptw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready
);

	`PTW_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	`PTW_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !m_axis_tvalid, "result valid after a reset cycle")

	`PTW_ASSERT(a_done_no_read, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0, "finished translation carries a read address")

	`PTW_ASSERT(a_read_clean, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[116:64] == 53'd0, "read request carries a translation or fault")

	`PTW_ASSERT(a_fault_zero, m_axis_tvalid && m_axis_tdata[116] |-> m_axis_tuser && m_axis_tdata[115:64] == 52'd0, "fault with a non-zero address")

endmodule

bind four_level_page_table_walker_core ptw_checker u_ptw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
